// ===== rtl/cfr_pkg.sv =====
// Shared types and constants for the filled circle rasterizer.
package cfr_pkg;

  localparam int COORD_W   = 13;  // signed center and scan coordinates
  localparam int POS_W     = 14;  // signed frame position, center plus offset
  localparam int RAD_W     = 11;  // radius and absolute offsets
  localparam int SQ_W      = 22;  // squared distances and squared radius
  localparam int COLOR_W   = 32;
  localparam int ADDR_W    = 22;
  localparam int CFG_W     = 12;  // frame dimension registers
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W  = 72;  // 69 payload bits padded to bytes
  localparam int M_DATA_W  = 56;  // 54 payload bits padded to bytes

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Snapshot of one bounding box position, taken when the item is accepted.
  typedef struct packed {
    logic                      visit;  // a real position, not a start or idle step
    logic                      done;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
    logic [RAD_W-1:0]          ax;
    logic [RAD_W-1:0]          ay;
    logic [SQ_W-1:0]           rr;
    logic [COLOR_W-1:0]        color;
  } item_t;

endpackage

// ===== rtl/cfr_pixel_pipe.sv =====
// Pixel test and address pipeline: snapshot, products, result register.
module cfr_pixel_pipe #(
  parameter int MAX_DIM = 2048
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cfr_pkg::CFG_W-1:0]   frame_width,
  input  logic [cfr_pkg::CFG_W-1:0]   frame_height,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cfr_pkg::item_t              in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        write_valid,
  output logic [cfr_pkg::ADDR_W-1:0]  pixel_address,
  output logic [cfr_pkg::COLOR_W-1:0] pixel_value,
  output logic                        done_res
);
  import cfr_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int LIM_W = ((DIM_W > POS_W) ? DIM_W : POS_W) + 1;
  localparam int PROD_W = ((COORD_W + DIM_W) > ADDR_W) ? (COORD_W + DIM_W) : ADDR_W;

  // Stage registers.
  logic   s1_valid;
  item_t  s1;
  logic                s2_valid;
  logic                s2_visit;
  logic                s2_done;
  logic                s2_in_frame;
  logic [SQ_W-1:0]     s2_ax2;
  logic [SQ_W-1:0]     s2_ay2;
  logic [SQ_W-1:0]     s2_rr;
  logic [ADDR_W-1:0]   s2_prod;
  logic [COORD_W-1:0]  s2_x;
  logic [COLOR_W-1:0]  s2_color;

  logic s2_move;
  logic s2_free;
  logic s1_move;
  logic out_slot;

  // Frame limits saturated to the largest supported dimension.
  logic [DIM_W-1:0]  lim_w;
  logic [DIM_W-1:0]  lim_h;
  logic              in_frame;
  logic [PROD_W-1:0] prod_full;
  logic [SQ_W:0]     dist_sum;
  logic              in_circle;

  // Each stage moves when the one after it is empty or moving.
  assign out_slot = !out_valid || out_ready;
  assign s2_move  = s2_valid && out_slot;
  assign s2_free  = !s2_valid || s2_move;
  assign s1_move  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s1_move;

  // Clipping test and row offset product.
  always_comb begin
    lim_w = (CMP_W'(frame_width) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(frame_width);
    lim_h = (CMP_W'(frame_height) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(frame_height);
    in_frame = !s1.x[POS_W-1] && !s1.y[POS_W-1] &&
               (LIM_W'($unsigned(s1.x)) < LIM_W'(lim_w)) &&
               (LIM_W'($unsigned(s1.y)) < LIM_W'(lim_h));
    prod_full = PROD_W'(s1.y[COORD_W-1:0]) * PROD_W'(lim_w);
  end

  // Distance compare and address add for the result register.
  assign dist_sum  = (SQ_W+1)'(s2_ax2) + (SQ_W+1)'(s2_ay2);
  assign in_circle = dist_sum <= (SQ_W+1)'(s2_rr);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (s2_free)  s2_valid <= s1_valid;
      if (out_slot) out_valid <= s2_valid;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= in_item;
    end
    if (s1_move) begin
      s2_visit    <= s1.visit;
      s2_done     <= s1.done;
      s2_in_frame <= in_frame;
      s2_ax2      <= SQ_W'(s1.ax) * SQ_W'(s1.ax);
      s2_ay2      <= SQ_W'(s1.ay) * SQ_W'(s1.ay);
      s2_rr       <= s1.rr;
      s2_prod     <= prod_full[ADDR_W-1:0];
      s2_x        <= s1.x[COORD_W-1:0];
      s2_color    <= s1.color;
    end
    if (s2_move) begin
      done_res <= s2_done;
      if (s2_visit && s2_in_frame && in_circle) begin
        write_valid   <= 1'b1;
        pixel_address <= s2_prod + ADDR_W'(s2_x);
        pixel_value   <= s2_color;
      end else begin
        write_valid   <= 1'b0;
        pixel_address <= '0;
        pixel_value   <= '0;
      end
    end
  end

endmodule

// ===== rtl/circle_fill_rasterizer.sv =====
// Top level of the bounding box filled circle rasterizer.
//
//  Channel  Direction  Signals                       Payload
//  s_axis   in         tvalid tready tdata tuser     start or step item
//  m_axis   out        tvalid tready tdata tuser     one result per item, tlast = done
//  cfg      in         valid ready index data        frame width and height
//
//  One item is accepted per cycle while s_axis_tready is high.
//  The scan counters advance at acceptance, so a step follows a step at full rate.
//  Results pass through two internal stages and a result register; a stalled
//  output fills those stages before s_axis_tready drops.
//  Synchronous reset sets the frame to 640 by 480 and the scanner idle.
//  Configuration writes are always ready and take effect at once; they belong
//  where no item is in flight.
module circle_fill_rasterizer #(
  parameter int MAX_DIM = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // center_x[12:0], center_y[25:13], radius[36:26], fill_color[68:37], zero pad
  input  logic [cfr_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // action[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_address[21:0], pixel_value[53:22], zero pad
  output logic [cfr_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // write_valid[0]
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfr_pkg::CFG_W-1:0]      cfg_data
);
  import cfr_pkg::*;

  // Configuration and scan state.
  logic [CFG_W-1:0]          frame_width;
  logic [CFG_W-1:0]          frame_height;
  logic                      busy;
  logic signed [COORD_W-1:0] scan_x;
  logic signed [COORD_W-1:0] scan_y;
  logic signed [COORD_W-1:0] held_center_x;
  logic signed [COORD_W-1:0] held_center_y;
  logic [RAD_W-1:0]          held_radius;
  logic [SQ_W-1:0]           held_rr;
  logic [COLOR_W-1:0]        held_color;

  logic                      accept;
  logic                      action;
  logic signed [COORD_W-1:0] in_center_x;
  logic signed [COORD_W-1:0] in_center_y;
  logic [RAD_W-1:0]          in_radius;
  logic [COLOR_W-1:0]        in_color;
  logic signed [COORD_W-1:0] rad_s;
  logic                      row_end;
  logic                      box_end;
  item_t                     snap;

  logic                      write_valid;
  logic [ADDR_W-1:0]         pixel_address;
  logic [COLOR_W-1:0]        pixel_value;
  logic                      done_res;

  // Unpack the input transaction.
  assign action      = s_axis_tuser;
  assign in_center_x = s_axis_tdata[12:0];
  assign in_center_y = s_axis_tdata[25:13];
  assign in_radius   = s_axis_tdata[36:26];
  assign in_color    = s_axis_tdata[68:37];
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready   = 1'b1;

  // End of row and end of box tests on the current position.
  assign rad_s   = $signed(COORD_W'(held_radius));
  assign row_end = scan_x >= rad_s;
  assign box_end = row_end && (scan_y >= rad_s);

  // Position snapshot handed to the pixel pipeline.
  always_comb begin
    snap.visit = action && busy;
    snap.done  = action && (!busy || box_end);
    snap.x     = POS_W'(held_center_x) + POS_W'(scan_x);
    snap.y     = POS_W'(held_center_y) + POS_W'(scan_y);
    snap.ax    = scan_x[COORD_W-1] ? RAD_W'(-scan_x) : RAD_W'(scan_x);
    snap.ay    = scan_y[COORD_W-1] ? RAD_W'(-scan_y) : RAD_W'(scan_y);
    snap.rr    = held_rr;
    snap.color = held_color;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_W'(640);
      frame_height <= CFG_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan counters: a start loads the top left corner, a step walks raster order.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      scan_x        <= '0;
      scan_y        <= '0;
      held_center_x <= '0;
      held_center_y <= '0;
      held_radius   <= '0;
      held_rr       <= '0;
      held_color    <= '0;
    end else if (accept) begin
      if (!action) begin
        held_center_x <= in_center_x;
        held_center_y <= in_center_y;
        held_radius   <= in_radius;
        held_rr       <= SQ_W'(in_radius) * SQ_W'(in_radius);
        held_color    <= in_color;
        scan_x        <= -$signed(COORD_W'(in_radius));
        scan_y        <= -$signed(COORD_W'(in_radius));
        busy          <= 1'b1;
      end else if (busy) begin
        if (box_end) begin
          busy <= 1'b0;
        end else if (row_end) begin
          scan_x <= -rad_s;
          scan_y <= scan_y + COORD_W'(1);
        end else begin
          scan_x <= scan_x + COORD_W'(1);
        end
      end
    end
  end

  cfr_pixel_pipe #(
    .MAX_DIM (MAX_DIM)
  ) u_pipe (
    .clk           (clk),
    .rst           (rst),
    .frame_width   (frame_width),
    .frame_height  (frame_height),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_item       (snap),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .write_valid   (write_valid),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .done_res      (done_res)
  );

  // Pack the output transaction.
  assign m_axis_tdata = {2'b00, pixel_value, pixel_address};
  assign m_axis_tuser = write_valid;
  assign m_axis_tlast = done_res;

  // The scanner leaves a circle only on an accepted step.
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(accept && action))
    else $error("scanner went idle without an accepted step");

  // The current position never leaves the bounding box.
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (scan_x <= rad_s && scan_x >= -rad_s && scan_y <= rad_s && scan_y >= -rad_s))
    else $error("scan position outside the bounding box");

  // With no result waiting, the pipeline always has room for a new item.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output is empty");

endmodule
